// ===== sv/csp_pkg.sv =====
// shared constants and codes for the cardinal spline point evaluator
// no dependencies
package csp_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] KIND_APPEND  = 2'd0;
    localparam logic [1:0] KIND_SET_PT  = 2'd1;
    localparam logic [1:0] KIND_SET_TAN = 2'd2;
    localparam logic [1:0] KIND_QUERY   = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    localparam logic signed [10:0] TENSION_RESET = 11'sd256;
    localparam logic [16:0]        T_ONE         = 17'd65536;

endpackage

// ===== sv/csp_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
module csp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/cardinal_spline_point_eval.sv =====
// cardinal spline point evaluator: control point table, tangent overrides, curve query
// depends on csp_pkg and csp_ram
//
// Usage: one input channel (i_in_valid / o_in_stall) carries items of four kinds:
// append a point, overwrite a point, set a tangent override, or query the curve
// at t. One result comes back on the output channel (o_out_valid / i_out_stall)
// for every item: the curve point for a query (zero otherwise) and a status.
// The tension register is written through i_cfg_we / i_cfg_data; the user must do
// so only while idle, the block does not enforce it. Points live in one ram of
// {y,x} pairs and overrides in a second one, each with one write and one
// registered read port. Items are handled one at a time: a table write ends at
// once, a query on a control point reads that point, and a full query runs the
// four point reads (one per cycle on the point port, overrides read alongside),
// the tangent multiply and the four sequential blend products.
// The result sits in an output register, so a stalled receiver holds it while
// the block takes the next item; the block only waits when a second result is
// ready before the first has been taken.
// Reset clears the point count, all override valid bits and sets tension to 1.0;
// the point ram keeps no reset value.
module cardinal_spline_point_eval (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic signed [10:0]          i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_kind,
    input  logic [7:0]                  i_index,
    input  logic signed [31:0]          i_x_in,
    input  logic signed [31:0]          i_y_in,
    input  logic [16:0]                 i_t,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [31:0]          o_x_out,
    output logic signed [31:0]          o_y_out,
    output logic [1:0]                  o_status
);
    import csp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SEG, S_PT, S_RD, S_TAN, S_TMUL, S_TRND, S_BL, S_FIN, S_DONE
    } t_state;

    t_state r_state;

    logic signed [10:0]       r_tension;
    logic [CNT_W-1:0]         r_count;
    logic [TABLE_DEPTH-1:0]   r_tan_vld;
    logic                     r_tvld_q;

    logic [IDX_W-1:0]         r_seg;
    logic [IDX_W-1:0]         r_nm1;
    logic [15:0]              r_u;
    logic [2:0]               r_step;

    logic [31:0]              r_u2;
    logic [47:0]              r_u3;
    logic signed [25:0]       r_h00, r_h01, r_h10, r_h11;

    logic signed [31:0]       r_pax, r_pay, r_pbx, r_pby, r_pcx, r_pcy, r_pdx, r_pdy;
    logic signed [31:0]       r_tax, r_tay, r_tbx, r_tby;
    logic                     r_ta_ok, r_tb_ok;

    logic signed [34:0]       r_dax, r_day, r_dbx, r_dby;
    logic signed [45:0]       r_max, r_may, r_mbx, r_mby;
    logic signed [37:0]       r_t1x, r_t1y, r_t2x, r_t2y;

    logic signed [63:0]       r_prx, r_pry;
    logic signed [65:0]       r_accx, r_accy;

    logic signed [31:0]       r_res_x, r_res_y;
    logic [1:0]               r_res_st;

    logic signed [31:0]       r_out_x, r_out_y;
    logic [1:0]               r_out_st;
    logic                     r_out_valid;

    // ram ports
    logic                     pt_we, tan_we;
    logic [IDX_W-1:0]         pt_waddr, pt_raddr, tan_raddr;
    logic [63:0]              pt_rdata, tan_rdata;

    logic                     in_xfer;
    logic                     out_free;

    logic [24:0]              ex;
    logic [16:0]              tq;

    logic signed [52:0]       w00, w10, w11;
    logic signed [52:0]       w00r, w10r, w11r;

    logic signed [34:0]       prev_a, next_b;
    logic signed [37:0]       opx, opy;
    logic signed [25:0]       opw;
    logic signed [65:0]       rx, ry;
    logic signed [41:0]       sx, sy;

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_x_out     = r_out_x;
    assign o_y_out     = r_out_y;
    assign o_status    = r_out_st;

    csp_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (pt_waddr),
        .i_wdata ({i_y_in, i_x_in}),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    csp_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_tan_ram (
        .i_clk   (i_clk),
        .i_we    (tan_we),
        .i_waddr (i_index[IDX_W-1:0]),
        .i_wdata ({i_y_in, i_x_in}),
        .i_raddr (tan_raddr),
        .o_rdata (tan_rdata)
    );

    // table writes happen in the cycle of the transfer
    always_comb begin
        pt_we  = 1'b0;
        tan_we = 1'b0;
        pt_waddr = i_index[IDX_W-1:0];
        if (in_xfer) begin
            case (i_kind)
                KIND_APPEND: begin
                    pt_we    = (r_count != CNT_W'(TABLE_DEPTH));
                    pt_waddr = r_count[IDX_W-1:0];
                end
                KIND_SET_PT:  pt_we  = ({1'b0, i_index} < 9'(r_count));
                KIND_SET_TAN: tan_we = ({1'b0, i_index} < 9'(r_count));
                default: ;
            endcase
        end
    end

    // read schedule: seg-1, seg, seg+1, seg+2 on points; seg, seg+1 on overrides
    always_comb begin
        pt_raddr  = r_seg;
        tan_raddr = r_seg;
        if (r_state == S_RD) begin
            case (r_step)
                3'd0: pt_raddr = (r_seg == '0) ? r_seg : r_seg - 1'b1;
                3'd1: begin
                    pt_raddr  = r_seg;
                    tan_raddr = r_seg + 1'b1;
                end
                3'd2: pt_raddr = r_seg + 1'b1;
                3'd3: pt_raddr = r_seg + 2'd2;
                default: pt_raddr = r_seg;
            endcase
        end
    end

    assign tq = (i_t > T_ONE) ? T_ONE : i_t;
    // n-1 taken from the full count so a full table gives 255 segments
    assign ex = 25'(tq) * 25'(r_count - 1'b1);

    // hermite weights in q0.48, rounded to q0.24
    always_comb begin
        w00  = (53'sd2 * $signed({5'd0, r_u3})) - (53'sd3 * $signed({5'd0, r_u2, 16'd0}))
             + (53'sd1 <<< 48);
        w10  = $signed({5'd0, r_u3}) - (53'sd2 * $signed({5'd0, r_u2, 16'd0}))
             + $signed({5'd0, r_u, 32'd0});
        w11  = $signed({5'd0, r_u3}) - $signed({5'd0, r_u2, 16'd0});
        w00r = (w00 + (53'sd1 <<< 23)) >>> 24;
        w10r = (w10 + (53'sd1 <<< 23)) >>> 24;
        w11r = (w11 + (53'sd1 <<< 23)) >>> 24;
    end

    // mirrored neighbors at the ends of the table
    assign prev_a = (r_seg == '0) ? (35'sd2 * 35'(r_pbx)) - 35'(r_pcx) : 35'(r_pax);
    assign next_b = ((r_seg + 1'b1) == r_nm1) ? (35'sd2 * 35'(r_pcx)) - 35'(r_pbx)
                                              : 35'(r_pdx);

    logic signed [34:0] prev_ay, next_by;
    assign prev_ay = (r_seg == '0) ? (35'sd2 * 35'(r_pby)) - 35'(r_pcy) : 35'(r_pay);
    assign next_by = ((r_seg + 1'b1) == r_nm1) ? (35'sd2 * 35'(r_pcy)) - 35'(r_pby)
                                               : 35'(r_pdy);

    always_comb begin
        case (r_step)
            3'd0: begin
                opx = 38'(r_pbx);
                opy = 38'(r_pby);
                opw = r_h00;
            end
            3'd1: begin
                opx = 38'(r_pcx);
                opy = 38'(r_pcy);
                opw = r_h01;
            end
            3'd2: begin
                opx = r_t1x;
                opy = r_t1y;
                opw = r_h10;
            end
            default: begin
                opx = r_t2x;
                opy = r_t2y;
                opw = r_h11;
            end
        endcase
    end

    assign rx = r_accx + (66'sd1 <<< 23);
    assign ry = r_accy + (66'sd1 <<< 23);
    assign sx = 42'(rx >>> 24);
    assign sy = 42'(ry >>> 24);

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        if (v > 42'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -42'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tension   <= TENSION_RESET;
            r_count     <= '0;
            r_tan_vld   <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tension <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_tvld_q <= r_tan_vld[tan_raddr];

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_res_x  <= '0;
                        r_res_y  <= '0;
                        r_res_st <= ST_DONE;
                        r_state  <= S_DONE;
                        r_seg    <= ex[16+IDX_W-1:16];
                        r_u      <= ex[15:0];
                        r_nm1    <= r_count[IDX_W-1:0] - 1'b1;
                        case (i_kind)
                            KIND_APPEND: begin
                                if (r_count == CNT_W'(TABLE_DEPTH)) begin
                                    r_res_st <= ST_IGNORED;
                                end else begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            KIND_SET_PT: begin
                                if ({1'b0, i_index} >= 9'(r_count)) begin
                                    r_res_st <= ST_IGNORED;
                                end
                            end
                            KIND_SET_TAN: begin
                                if ({1'b0, i_index} >= 9'(r_count)) begin
                                    r_res_st <= ST_IGNORED;
                                end else begin
                                    r_tan_vld[i_index[IDX_W-1:0]] <= 1'b1;
                                end
                            end
                            default: begin
                                if (r_count == '0) begin
                                    r_res_st <= ST_EMPTY;
                                end else begin
                                    r_state <= S_SEG;
                                end
                            end
                        endcase
                    end
                end
                S_SEG: begin
                    r_step <= '0;
                    if (r_u == '0 || r_seg >= r_nm1) begin
                        r_state <= S_PT;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_PT: begin
                    r_res_x <= pt_rdata[31:0];
                    r_res_y <= pt_rdata[63:32];
                    r_state <= S_DONE;
                end
                S_RD: begin
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        3'd0: r_u2 <= r_u * r_u;
                        3'd1: begin
                            r_u3    <= r_u2 * r_u;
                            r_pax   <= pt_rdata[31:0];
                            r_pay   <= pt_rdata[63:32];
                            r_tax   <= tan_rdata[31:0];
                            r_tay   <= tan_rdata[63:32];
                            r_ta_ok <= r_tvld_q;
                        end
                        3'd2: begin
                            r_h00   <= 26'(w00r);
                            r_h01   <= (26'sd1 <<< 24) - 26'(w00r);
                            r_h10   <= 26'(w10r);
                            r_h11   <= 26'(w11r);
                            r_pbx   <= pt_rdata[31:0];
                            r_pby   <= pt_rdata[63:32];
                            r_tbx   <= tan_rdata[31:0];
                            r_tby   <= tan_rdata[63:32];
                            r_tb_ok <= r_tvld_q;
                        end
                        3'd3: begin
                            r_pcx <= pt_rdata[31:0];
                            r_pcy <= pt_rdata[63:32];
                        end
                        default: begin
                            r_pdx   <= pt_rdata[31:0];
                            r_pdy   <= pt_rdata[63:32];
                            r_state <= S_TAN;
                        end
                    endcase
                end
                S_TAN: begin
                    r_dax   <= 35'(r_pcx) - prev_a;
                    r_day   <= 35'(r_pcy) - prev_ay;
                    r_dbx   <= next_b - 35'(r_pbx);
                    r_dby   <= next_by - 35'(r_pby);
                    r_state <= S_TMUL;
                end
                S_TMUL: begin
                    r_max   <= r_dax * r_tension;
                    r_may   <= r_day * r_tension;
                    r_mbx   <= r_dbx * r_tension;
                    r_mby   <= r_dby * r_tension;
                    r_state <= S_TRND;
                end
                S_TRND: begin
                    if (r_ta_ok && (r_tax != '0 || r_tay != '0)) begin
                        r_t1x <= 38'(r_tax);
                        r_t1y <= 38'(r_tay);
                    end else begin
                        r_t1x <= 38'((r_max + 46'sd128) >>> 8);
                        r_t1y <= 38'((r_may + 46'sd128) >>> 8);
                    end
                    if (r_tb_ok && (r_tbx != '0 || r_tby != '0)) begin
                        r_t2x <= 38'(r_tbx);
                        r_t2y <= 38'(r_tby);
                    end else begin
                        r_t2x <= 38'((r_mbx + 46'sd128) >>> 8);
                        r_t2y <= 38'((r_mby + 46'sd128) >>> 8);
                    end
                    r_accx  <= '0;
                    r_accy  <= '0;
                    r_step  <= '0;
                    r_state <= S_BL;
                end
                S_BL: begin
                    // product of step k lands in the accumulator at step k+1
                    r_step <= r_step + 1'b1;
                    r_prx  <= opx * opw;
                    r_pry  <= opy * opw;
                    if (r_step != '0) begin
                        r_accx <= r_accx + 66'(r_prx);
                        r_accy <= r_accy + 66'(r_pry);
                    end
                    if (r_step == 3'd4) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_res_x <= sat32(sx);
                    r_res_y <= sat32(sy);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_x     <= r_res_x;
                        r_out_y     <= r_res_y;
                        r_out_st    <= r_res_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
